>>> hw/rtl/rpn_integer_evaluator_macros.svh
// Assertion macros used by the evaluator RTL
`ifndef RPN_INTEGER_EVALUATOR_MACROS_SVH
`define RPN_INTEGER_EVALUATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define RPN_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define RPN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/rpn_pkg.sv
// Package: widths, character codes, status codes and token types of the evaluator
`timescale 1ns / 1ps
`default_nettype none

package rpn_pkg;

   localparam int STACK_DEPTH_DEF = 64;
   localparam int DATA_W          = 32;
   localparam int CHAR_W          = 8;
   localparam int STATUS_W        = 3;
   localparam int DIGIT_W         = 4;
   localparam int QUEUE_DEPTH     = 4;

   // Characters of the expression stream
   localparam logic [CHAR_W-1:0] CHAR_0     = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_9     = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'h2A;
   localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
   localparam logic [CHAR_W-1:0] CHAR_EQUAL = 8'h3D;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_VALUE    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_TOO_MANY = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_FEW  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_DIV_ZERO = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_BAD_CHAR = 3'd5;

   typedef enum logic [2:0] {
      TOK_DIGIT,
      TOK_ADD,
      TOK_SUB,
      TOK_MUL,
      TOK_DIV,
      TOK_EQUAL,
      TOK_BAD,
      TOK_SPACE
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type       kind;
      logic [DIGIT_W-1:0] digit;
   } token_type;

   typedef struct packed {
      logic      valid;
      token_type token;
   } tokq_head_type;

endpackage

`default_nettype wire

>>> hw/rtl/rpn_if.sv
// Interfaces: character request channel and result channel
`timescale 1ns / 1ps
`default_nettype none

interface rpn_req_if import rpn_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_byte;

   modport source (output valid, output char_byte, input ready);
   modport sink   (input valid, input char_byte, output ready);
endinterface

interface rpn_rsp_if import rpn_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic signed [DATA_W-1:0]   result_value;

   modport source (output valid, output status, output result_value, input ready);
   modport sink   (input valid, input status, input result_value, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rpn_front.sv
// Front end: accepts characters, classifies them and drops whitespace
`timescale 1ns / 1ps
`default_nettype none

module rpn_front import rpn_pkg::*; (
   rpn_req_if.sink          req_chan,
   input  logic             q_full,
   output logic             q_push,
   output token_type        q_token
);

   logic [CHAR_W-1:0] digit_off;

   assign digit_off = req_chan.char_byte - CHAR_0;

   // Classify the incoming character
   always_comb begin
      q_token.digit = digit_off[DIGIT_W-1:0];
      unique case (req_chan.char_byte) inside
         [CHAR_0:CHAR_9]:          q_token.kind = TOK_DIGIT;
         CHAR_PLUS:                q_token.kind = TOK_ADD;
         CHAR_MINUS:               q_token.kind = TOK_SUB;
         CHAR_STAR:                q_token.kind = TOK_MUL;
         CHAR_SLASH:               q_token.kind = TOK_DIV;
         CHAR_EQUAL:               q_token.kind = TOK_EQUAL;
         CHAR_SPACE, [CHAR_TAB:CHAR_CR]: q_token.kind = TOK_SPACE;
         default:                  q_token.kind = TOK_BAD;
      endcase
   end

   // Take an item whenever the queue has room; whitespace never enters it
   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full && (q_token.kind != TOK_SPACE);

endmodule

`default_nettype wire

>>> hw/rtl/rpn_tokq.sv
// Token queue between the front end and the execution unit
`timescale 1ns / 1ps
`default_nettype none

module rpn_tokq import rpn_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  token_type     push_token,
   output logic          full,
   input  logic          pop,
   output tokq_head_type head
);

   localparam int PtrW = $clog2(QUEUE_DEPTH);

   token_type         slot_ff [QUEUE_DEPTH];
   logic [PtrW:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW:0]     rd_ptr_ff, rd_ptr_in;
   logic              empty;

   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign full  = (wr_ptr_ff[PtrW] != rd_ptr_ff[PtrW]) &&
                  (wr_ptr_ff[PtrW-1:0] == rd_ptr_ff[PtrW-1:0]);

   assign head.valid = !empty;
   assign head.token = slot_ff[rd_ptr_ff[PtrW-1:0]];

   // Advance pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push && !full) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop && !empty) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Store tokens
   always_ff @(posedge clock) begin
      if (push && !full) begin
         slot_ff[wr_ptr_ff[PtrW-1:0]] <= push_token;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/rpn_div.sv
// Radix-2 restoring divider, signed, quotient truncated toward zero
`timescale 1ns / 1ps
`default_nettype none

module rpn_div import rpn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DATA_W-1:0] dividend,
   input  logic [DATA_W-1:0] divisor,
   output logic              done,
   output logic [DATA_W-1:0] quotient
);

   localparam int StepW = $clog2(DATA_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [StepW-1:0]  step_ff, step_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] dmag_ff, dmag_in;
   logic              neg_ff, neg_in;
   logic [DATA_W:0]   shifted;
   logic [DATA_W:0]   trial;

   // One quotient bit per cycle
   assign shifted = {rem_ff, quo_ff[DATA_W-1]};
   assign trial   = shifted - {1'b0, dmag_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dmag_in = dmag_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend[DATA_W-1] ? (-dividend) : dividend;
         dmag_in = divisor[DATA_W-1] ? (-divisor) : divisor;
         neg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
      end else if (busy_ff) begin
         if (!trial[DATA_W]) begin
            rem_in = trial[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dmag_ff <= dmag_in;
      neg_ff  <= neg_in;
   end

   // Apply the sign on the way out
   assign done     = done_ff;
   assign quotient = neg_ff ? (-quo_ff) : quo_ff;

endmodule

`default_nettype wire

>>> hw/rtl/rpn_back.sv
// Execution unit: operand stack, arithmetic and the result register
`timescale 1ns / 1ps
`default_nettype none
`include "rpn_integer_evaluator_macros.svh"

module rpn_back import rpn_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  tokq_head_type head,
   output logic          pop,
   rpn_rsp_if.source     rsp_chan
);

   localparam int CountW = $clog2(STACK_DEPTH + 1);
   localparam int AddrW  = $clog2(STACK_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MUL  = 4'b0010,
      S_DIV  = 4'b0100,
      S_LOAD = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [CountW-1:0]   count_ff, count_in;
   logic                err_ff, err_in;
   logic [DATA_W-1:0]   top_ff, top_in;
   logic [DATA_W-1:0]   next_ff, next_in;
   logic [DATA_W-1:0]   prod_ff, prod_in;
   logic [DATA_W-1:0]   stack_ff [STACK_DEPTH];
   logic [DATA_W-1:0]   rd_data_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0]   rsp_value_ff, rsp_value_in;

   logic                out_free;
   logic                emit;
   logic [STATUS_W-1:0] emit_status;
   logic [DATA_W-1:0]   emit_value;
   logic                mem_we;
   logic [AddrW-1:0]    mem_waddr;
   logic                rd_en;
   logic [AddrW-1:0]    rd_addr;
   logic                wb;
   logic [DATA_W-1:0]   wb_value;
   logic                div_start;
   logic                div_done;
   logic [DATA_W-1:0]   div_quot;

   rpn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (next_ff),
      .divisor  (top_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Top two operands live in registers; deeper ones in the memory
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign mem_waddr = AddrW'(count_ff - CountW'(2));
   assign rd_addr   = AddrW'(count_ff - CountW'(3));

   // Execute tokens
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      err_in      = err_ff;
      top_in      = top_ff;
      next_in     = next_ff;
      prod_in     = prod_ff;
      pop         = 1'b0;
      emit        = 1'b0;
      emit_status = STATUS_VALUE;
      emit_value  = '0;
      mem_we      = 1'b0;
      rd_en       = 1'b0;
      wb          = 1'b0;
      wb_value    = prod_ff;
      div_start   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (head.valid && out_free) begin
               pop = 1'b1;
               unique case (head.token.kind)
                  TOK_DIGIT: begin
                     if (!err_ff) begin
                        if (count_ff == CountW'(STACK_DEPTH)) begin
                           emit        = 1'b1;
                           emit_status = STATUS_OVERFLOW;
                           err_in      = 1'b1;
                        end else begin
                           mem_we   = (count_ff >= CountW'(2));
                           next_in  = top_ff;
                           top_in   = {{(DATA_W-DIGIT_W){1'b0}}, head.token.digit};
                           count_in = count_ff + 1'b1;
                        end
                     end
                  end
                  TOK_ADD, TOK_SUB, TOK_MUL, TOK_DIV: begin
                     if (!err_ff) begin
                        if (count_ff < CountW'(2)) begin
                           emit        = 1'b1;
                           emit_status = STATUS_TOO_FEW;
                           err_in      = 1'b1;
                        end else begin
                           case (head.token.kind)
                              TOK_ADD: begin
                                 wb       = 1'b1;
                                 wb_value = next_ff + top_ff;
                              end
                              TOK_SUB: begin
                                 wb       = 1'b1;
                                 wb_value = next_ff - top_ff;
                              end
                              TOK_MUL: begin
                                 prod_in  = next_ff * top_ff;
                                 state_in = S_MUL;
                              end
                              default: begin
                                 if (top_ff == '0) begin
                                    emit        = 1'b1;
                                    emit_status = STATUS_DIV_ZERO;
                                    err_in      = 1'b1;
                                 end else begin
                                    div_start = 1'b1;
                                    state_in  = S_DIV;
                                 end
                              end
                           endcase
                        end
                     end
                  end
                  TOK_EQUAL: begin
                     if (!err_ff) begin
                        emit = 1'b1;
                        if (count_ff == CountW'(1)) begin
                           emit_status = STATUS_VALUE;
                           emit_value  = top_ff;
                        end else begin
                           emit_status = STATUS_TOO_MANY;
                        end
                     end
                     count_in = '0;
                     err_in   = 1'b0;
                  end
                  TOK_BAD: begin
                     if (!err_ff) begin
                        emit        = 1'b1;
                        emit_status = STATUS_BAD_CHAR;
                        count_in    = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MUL: begin
            wb       = 1'b1;
            wb_value = prod_ff;
         end
         S_DIV: begin
            if (div_done) begin
               wb       = 1'b1;
               wb_value = div_quot;
            end
         end
         S_LOAD: begin
            next_in  = rd_data_ff;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Write back a result; refill the second operand from memory
      if (wb) begin
         top_in   = wb_value;
         count_in = count_ff - 1'b1;
         if (count_ff >= CountW'(3)) begin
            rd_en    = 1'b1;
            state_in = S_LOAD;
         end else begin
            state_in = S_IDLE;
         end
      end
   end

   // Hold the result until taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = emit_status;
         rsp_value_in  = emit_value;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff        <= top_in;
      next_ff       <= next_in;
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // Operand memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_ff[mem_waddr] <= next_ff;
      end
      if (rd_en) begin
         rd_data_ff <= stack_ff[rd_addr];
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.result_value = rsp_value_ff;

   `RPN_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CountW'(STACK_DEPTH), "stack count beyond depth")
   `RPN_ASSERT_IMPL(a_div_done_state, clock, reset, div_done, state_ff == S_DIV, "divider finished outside divide state")
   `RPN_ASSERT_IMPL(a_load_depth, clock, reset, state_ff == S_LOAD, count_ff >= CountW'(2), "refill with fewer than two operands")
   `RPN_ASSERT_IMPL(a_error_reported, clock, reset, $rose(err_ff), rsp_valid_ff && (rsp_status_ff != STATUS_VALUE), "error raised without a report")
   `RPN_ASSERT_NEXT(a_mul_writeback, clock, reset, state_ff == S_MUL, (state_ff == S_IDLE) || (state_ff == S_LOAD), "multiply did not write back")

endmodule

`default_nettype wire

>>> hw/rtl/rpn_integer_evaluator.sv
// Top level: reverse Polish integer expression evaluator
//
// req_chan carries one ASCII character per item (valid/ready, taken when both
// are high). Digits push 0-9, + - * / combine the top two operands with 32-bit
// wrap (division truncates toward zero), '=' reports the value or "too many
// operands" and empties the stack. Whitespace is dropped on entry.
// rsp_chan carries at most one result item per character: a status code and
// result_value, which is zero for every status other than a value.
// A character waits in a four-entry token queue; the execution unit handles
// digits, '=', errors and + - directly, refills the second operand from the
// stack memory after an operation when three or more operands are held, uses
// a registered multiply for '*', and waits on '/' for the radix-2 divider,
// which produces one quotient bit per cycle.
// Reset clears the stack count, the error flag, the queue and the result
// valid flag; stack memory needs no clearing. A stalled rsp_chan holds its
// result, the execution unit then stops, and req_chan keeps taking items
// until the token queue is full.
`timescale 1ns / 1ps
`default_nettype none

module rpn_integer_evaluator import rpn_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   rpn_req_if.sink   req_chan,
   rpn_rsp_if.source rsp_chan
);

   logic          q_full;
   logic          q_push;
   token_type     q_token;
   logic          q_pop;
   tokq_head_type q_head;

   rpn_front u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_token  (q_token)
   );

   rpn_tokq u_tokq (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_token (q_token),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head)
   );

   rpn_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (q_head),
      .pop      (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
